// ===== rtl/core/sha1md_pkg.sv =====
// Shared types and constants of the SHA-1 message digest block.
`timescale 1ns / 1ps
`default_nettype none
package sha1md_pkg;

   // initial chain value
   localparam logic [31:0] IV0 = 32'h67452301;
   localparam logic [31:0] IV1 = 32'hEFCDAB89;
   localparam logic [31:0] IV2 = 32'h98BADCFE;
   localparam logic [31:0] IV3 = 32'h10325476;
   localparam logic [31:0] IV4 = 32'hC3D2E1F0;

   // round constants
   localparam logic [31:0] K0 = 32'h5A827999;
   localparam logic [31:0] K1 = 32'h6ED9EBA1;
   localparam logic [31:0] K2 = 32'h8F1BBCDC;
   localparam logic [31:0] K3 = 32'hCA62C1D6;

   localparam logic [7:0] PAD_MARKER = 8'h80;

   // round counter marks
   localparam logic [6:0] ROUND_SCHED = 7'd16;
   localparam logic [6:0] ROUND_GRP1  = 7'd20;
   localparam logic [6:0] ROUND_GRP2  = 7'd40;
   localparam logic [6:0] ROUND_GRP3  = 7'd60;
   localparam logic [6:0] ROUND_LAST  = 7'd79;

   // block fill marks (bytes already in the block)
   localparam logic [5:0] FILL_LEN  = 6'd56;
   localparam logic [5:0] FILL_LAST = 6'd63;

   localparam logic [2:0] WORD_LAST = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_ADD,
      ST_PAD,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      PH_MARK,
      PH_ZERO,
      PH_LEN,
      PH_DONE
   } phase_type;

   // round unit controls
   typedef struct packed {
      logic load;
      logic step;
      logic add;
      logic init;
   } rnd_ctl_type;

   // schedule window controls
   typedef struct packed {
      logic push;
      logic step;
      logic expand;
   } sch_ctl_type;

endpackage
`default_nettype wire

// ===== rtl/core/sha1md_sched.sv =====
// Message schedule window: byte loader and 16-word expansion shift line.
`timescale 1ns / 1ps
`default_nettype none
module sha1md_sched (
   input  wire logic                      clock,
   input  wire sha1md_pkg::sch_ctl_type   ctl,
   input  wire logic [7:0]                push_byte,
   output logic [31:0]                    w_out
);
   import sha1md_pkg::*;

   // word k sits at bits [511-32k -: 32]; the newest byte enters at the bottom
   logic [511:0] win_ff, win_in;
   logic [31:0]  w0, w2, w8, w13, w_mix;

   assign w0  = win_ff[511:480];
   assign w2  = win_ff[447:416];
   assign w8  = win_ff[255:224];
   assign w13 = win_ff[95:64];
   assign w_mix = w13 ^ w8 ^ w2 ^ w0;

   // word of the current round
   assign w_out = ctl.expand ? {w_mix[30:0], w_mix[31]} : w0;

   always_comb begin
      win_in = win_ff;
      if (ctl.push) begin
         win_in = {win_ff[503:0], push_byte};
      end else if (ctl.step) begin
         win_in = {win_ff[479:0], w_out};
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

endmodule
`default_nettype wire

// ===== rtl/core/sha1md_round.sv =====
// Shared SHA-1 round unit with working variables and chain value.
`timescale 1ns / 1ps
`default_nettype none
module sha1md_round (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire sha1md_pkg::rnd_ctl_type   ctl,
   input  wire logic [6:0]                round,
   input  wire logic [31:0]               w_in,
   output logic [4:0][31:0]               chain_out
);
   import sha1md_pkg::*;

   logic [4:0][31:0] chain_ff, chain_in;
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0] a_in, b_in, c_in, d_in, e_in;
   logic [31:0] f_val, k_val, t_val;

   // round function and constant by round group
   always_comb begin
      if (round < ROUND_GRP1) begin
         f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         k_val = K0;
      end else if (round < ROUND_GRP2) begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = K1;
      end else if (round < ROUND_GRP3) begin
         f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         k_val = K2;
      end else begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = K3;
      end
   end

   assign t_val = {a_ff[26:0], a_ff[31:27]} + f_val + e_ff + k_val + w_in;

   // next values
   always_comb begin
      chain_in = chain_ff;
      a_in = a_ff;
      b_in = b_ff;
      c_in = c_ff;
      d_in = d_ff;
      e_in = e_ff;
      if (ctl.init) begin
         chain_in = {IV4, IV3, IV2, IV1, IV0};
         a_in = '0;
         b_in = '0;
         c_in = '0;
         d_in = '0;
         e_in = '0;
      end else if (ctl.load) begin
         a_in = chain_ff[0];
         b_in = chain_ff[1];
         c_in = chain_ff[2];
         d_in = chain_ff[3];
         e_in = chain_ff[4];
      end else if (ctl.step) begin
         a_in = t_val;
         b_in = a_ff;
         c_in = {b_ff[1:0], b_ff[31:2]};
         d_in = c_ff;
         e_in = d_ff;
      end else if (ctl.add) begin
         chain_in[0] = chain_ff[0] + a_ff;
         chain_in[1] = chain_ff[1] + b_ff;
         chain_in[2] = chain_ff[2] + c_ff;
         chain_in[3] = chain_ff[3] + d_ff;
         chain_in[4] = chain_ff[4] + e_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= {IV4, IV3, IV2, IV1, IV0};
         a_ff <= '0;
         b_ff <= '0;
         c_ff <= '0;
         d_ff <= '0;
         e_ff <= '0;
      end else begin
         chain_ff <= chain_in;
         a_ff <= a_in;
         b_ff <= b_in;
         c_ff <= c_in;
         d_ff <= d_in;
         e_ff <= e_in;
      end
   end

   assign chain_out = chain_ff;

endmodule
`default_nettype wire

// ===== rtl/core/sha1_message_digest.sv =====
// Top level of the SHA-1 message digest: sequencer, byte counter and digest output.
//
// Usage: message bytes enter on the req_ channel, one beat per byte, most
// significant byte first. req_tuser[0] says the beat carries a byte in
// req_tdata[7:0]; req_tlast ends the message (with or without a byte).
// After the last beat the block pads the message, runs the final blocks and
// sends the 160-bit digest on the rsp_ channel as five 32-bit beats, word 0
// (most significant) first, index in rsp_tuser, rsp_tlast on the fifth.
// Byte beats are taken only in the idle state: the 64th byte of a block starts
// the 80 rounds on the single round unit and then the chain update, and no
// beat is taken until both are done. Padding after the last beat has up to 72
// bytes, with a second block when the marker leaves more than 56 bytes.
// req_tready is low whenever the block is compressing, padding or sending.
// A stalled receiver holds the digest beat steady; nothing is lost.
// Reset (synchronous, active high) loads the initial chain value and clears
// the byte count; after the fifth digest beat the block returns to that state.
`timescale 1ns / 1ps
`default_nettype none
module sha1_message_digest (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [7:0]    req_tdata,   // [7:0] data_byte
   input  wire logic [0:0]    req_tuser,   // [0] has_byte
   input  wire logic          req_tlast,   // last
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [31:0]        rsp_tdata,   // [31:0] digest_word
   output logic [2:0]         rsp_tuser,   // [2:0] word_index
   output logic               rsp_tlast    // last_word
);
   import sha1md_pkg::*;

   state_type   state_ff, state_in;
   phase_type   phase_ff, phase_in;
   logic [5:0]  fill_ff, fill_in;
   logic [31:0] count_ff, count_in;
   logic [6:0]  round_ff, round_in;
   logic        ending_ff, ending_in;
   logic [2:0]  idx_ff, idx_in;

   rnd_ctl_type      rctl;
   sch_ctl_type      sctl;
   logic [7:0]       push_data;
   logic [31:0]      w_cur;
   logic [4:0][31:0] chain;
   logic [63:0]      len_bits;
   logic [63:0]      len_shift;
   logic [7:0]       len_byte;

   // length field byte for the current fill position
   assign len_bits  = {29'd0, count_ff, 3'd0};
   assign len_shift = len_bits >> {~fill_ff[2:0], 3'b000};
   assign len_byte  = len_shift[7:0];

   // sequencer
   always_comb begin
      state_in   = state_ff;
      phase_in   = phase_ff;
      fill_in    = fill_ff;
      count_in   = count_ff;
      round_in   = round_ff;
      ending_in  = ending_ff;
      idx_in     = idx_ff;
      rctl       = '0;
      sctl       = '0;
      push_data  = req_tdata;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_tuser[0]) begin
                  sctl.push = 1'b1;
                  if (count_ff != '1) begin
                     count_in = count_ff + 32'd1;
                  end
               end
               if (req_tlast) begin
                  ending_in = 1'b1;
                  state_in  = ST_PAD;
               end
            end
         end
         ST_ROUND: begin
            rctl.step   = 1'b1;
            sctl.step   = 1'b1;
            sctl.expand = (round_ff >= ROUND_SCHED);
            if (round_ff == ROUND_LAST) begin
               round_in = '0;
               state_in = ST_ADD;
            end else begin
               round_in = round_ff + 7'd1;
            end
         end
         ST_ADD: begin
            rctl.add = 1'b1;
            if (!ending_ff) begin
               state_in = ST_IDLE;
            end else if (phase_ff == PH_DONE) begin
               idx_in   = '0;
               state_in = ST_OUT;
            end else begin
               state_in = ST_PAD;
            end
         end
         ST_PAD: begin
            case (phase_ff)
               PH_MARK: begin
                  sctl.push = 1'b1;
                  push_data = PAD_MARKER;
                  phase_in  = PH_ZERO;
               end
               PH_ZERO: begin
                  if (fill_ff == FILL_LEN) begin
                     phase_in = PH_LEN;
                  end else begin
                     sctl.push = 1'b1;
                     push_data = '0;
                  end
               end
               PH_LEN: begin
                  sctl.push = 1'b1;
                  push_data = len_byte;
                  if (fill_ff == FILL_LAST) begin
                     phase_in = PH_DONE;
                  end
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end
         ST_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == WORD_LAST) begin
                  rctl.init = 1'b1;
                  idx_in    = '0;
                  count_in  = '0;
                  phase_in  = PH_MARK;
                  ending_in = 1'b0;
                  state_in  = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // a byte that completes the block starts the rounds
      if (sctl.push) begin
         fill_in = fill_ff + 6'd1;
         if (fill_ff == FILL_LAST) begin
            rctl.load = 1'b1;
            round_in  = '0;
            state_in  = ST_ROUND;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         phase_ff  <= PH_MARK;
         fill_ff   <= '0;
         count_ff  <= '0;
         round_ff  <= '0;
         ending_ff <= 1'b0;
         idx_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         phase_ff  <= phase_in;
         fill_ff   <= fill_in;
         count_ff  <= count_in;
         round_ff  <= round_in;
         ending_ff <= ending_in;
         idx_ff    <= idx_in;
      end
   end

   sha1md_sched u_sched (
      .clock     (clock),
      .ctl       (sctl),
      .push_byte (push_data),
      .w_out     (w_cur)
   );

   sha1md_round u_round (
      .clock     (clock),
      .reset     (reset),
      .ctl       (rctl),
      .round     (round_ff),
      .w_in      (w_cur),
      .chain_out (chain)
   );

   // digest beat straight from the chain value
   assign rsp_tdata = chain[idx_ff];
   assign rsp_tuser = idx_ff;
   assign rsp_tlast = (idx_ff == WORD_LAST);

   // input is never taken while a digest beat is pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input accepted while digest pending");

   a_round_range: assert property (@(posedge clock) disable iff (reset)
      round_ff <= ROUND_LAST)
      else $error("round counter out of range");

   a_round_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && round_ff == ROUND_LAST) |=> (state_ff == ST_ADD))
      else $error("rounds did not end in chain update");

   a_msg_restart: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=>
         (req_tready && fill_ff == '0 && count_ff == '0))
      else $error("block not back to start after digest");

endmodule
`default_nettype wire

// ===== verif/sha1_digest_sb_pkg.sv =====
// Digest predictor and scoreboard for the SHA-1 message digest testbench.
`timescale 1ns / 1ps
package sha1_digest_sb_pkg;
   import sha1md_pkg::*;

   // one expected digest beat
   typedef struct {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_beat_type;

   class digest_scoreboard;
      logic [31:0]  chain [5];
      logic [31:0]  sched [16];
      logic [31:0]  byte_count;
      int unsigned  fill;
      digest_beat_type expected_words [$];
      int unsigned  errors;
      int unsigned  words_checked;
      int unsigned  messages_hashed;
      int unsigned  blocks_compressed;

      function new();
         errors            = 0;
         words_checked     = 0;
         messages_hashed   = 0;
         blocks_compressed = 0;
         restart();
      endfunction

      // back to the start of a message
      function void restart();
         chain[0]   = IV0;
         chain[1]   = IV1;
         chain[2]   = IV2;
         chain[3]   = IV3;
         chain[4]   = IV4;
         byte_count = '0;
         fill       = 0;
         foreach (sched[i]) sched[i] = '0;
      endfunction

      function logic [31:0] rotl(logic [31:0] v, int n);
         return (v << n) | (v >> (32 - n));
      endfunction

      // bytes shift in big-endian within each schedule word
      function void put_byte(logic [7:0] b);
         int unsigned slot;
         slot        = (fill >> 2) & 15;
         sched[slot] = {sched[slot][23:0], b};
         fill++;
      endfunction

      // 80 rounds over the window, then fold into the chain value
      function void compress();
         logic [31:0] a, b, c, d, e, f, k, w, tmp;
         a = chain[0];
         b = chain[1];
         c = chain[2];
         d = chain[3];
         e = chain[4];
         for (int t = 0; t < 80; t++) begin
            if (t >= 16) begin
               w = sched[(t - 3) & 15] ^ sched[(t - 8) & 15] ^
                   sched[(t - 14) & 15] ^ sched[t & 15];
               sched[t & 15] = rotl(w, 1);
            end
            w = sched[t & 15];
            if (t < 20) begin
               f = (b & c) | (~b & d);
               k = K0;
            end else if (t < 40) begin
               f = b ^ c ^ d;
               k = K1;
            end else if (t < 60) begin
               f = (b & c) | (b & d) | (c & d);
               k = K2;
            end else begin
               f = b ^ c ^ d;
               k = K3;
            end
            tmp = rotl(a, 5) + f + e + k + w;
            e   = d;
            d   = c;
            c   = rotl(b, 30);
            b   = a;
            a   = tmp;
         end
         chain[0] += a;
         chain[1] += b;
         chain[2] += c;
         chain[3] += d;
         chain[4] += e;
         fill = 0;
         blocks_compressed++;
      endfunction

      // accepted request beat: absorb the byte, pad and queue the digest on last
      function void note_beat(logic [7:0] data, logic has, logic last);
         logic [63:0]     bit_len;
         digest_beat_type beat;
         if (has) begin
            put_byte(data);
            if (byte_count != 32'hFFFF_FFFF) byte_count++;
            if (fill >= 64) compress();
         end
         if (!last) return;
         bit_len = {29'd0, byte_count, 3'd0};
         put_byte(PAD_MARKER);
         // marker past 56 bytes: length goes into an extra block
         if (fill > 56) begin
            while (fill < 64) put_byte(8'h00);
            compress();
         end
         while (fill < 56) put_byte(8'h00);
         for (int i = 0; i < 8; i++) put_byte(bit_len[63 - 8 * i -: 8]);
         compress();
         for (int i = 0; i < 5; i++) begin
            beat.word  = chain[i];
            beat.index = 3'(i);
            beat.last  = (3'(i) == WORD_LAST);
            expected_words.push_back(beat);
         end
         messages_hashed++;
         restart();
      endfunction

      task report(string what);
         $display("[%0t] digest beat %0d: %s", $time, words_checked, what);
         errors++;
      endtask

      // accepted response beat against the oldest expected word
      task check_word(logic [31:0] word, logic [2:0] index, logic last);
         digest_beat_type want;
         if (expected_words.size() == 0) begin
            report($sformatf("unexpected word %h index %0d", word, index));
            return;
         end
         want = expected_words.pop_front();
         if (word !== want.word)
            report($sformatf("word %h, wanted %h", word, want.word));
         if (index !== want.index)
            report($sformatf("index %0d, wanted %0d", index, want.index));
         if (last !== want.last)
            report($sformatf("last %b, wanted %b", last, want.last));
         words_checked++;
      endtask

      function int unsigned pending();
         return expected_words.size();
      endfunction
   endclass

endpackage

// ===== verif/tb_top.sv =====
// Top of the SHA-1 message digest testbench: clock, reset, stream drivers and checks.
`timescale 1ns / 1ps
module tb_top;
   import sha1md_pkg::*;
   import sha1_digest_sb_pkg::*;

   localparam int unsigned ITEM_TARGET  = 380;
   localparam int unsigned CYCLE_LIMIT  = 1000000;
   localparam int unsigned HOLD_CYCLES  = 400;
   localparam int unsigned HOLD_AFTER   = 30;
   localparam int unsigned DRAIN_CYCLES = 40;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;
   logic [0:0]  req_tuser  = 1'b0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   digest_scoreboard digest_sb = new();

   int unsigned cycle_count = 0;
   int unsigned items_sent  = 0;
   int unsigned bare_steps  = 0;
   bit          pace_gaps   = 1'b0;

   sha1_message_digest u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // run limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("timeout after %0d cycles, %0d words still due",
               cycle_count, digest_sb.pending());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // one request beat, with an optional idle gap in front
   task send_beat(input logic [7:0] data, input logic has, input logic last);
      int unsigned gap;
      gap = pace_gaps ? $urandom_range(0, 4) : 0;
      repeat (gap) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= has;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      digest_sb.note_beat(data, has, last);
      if (has || last) items_sent++;
      else bare_steps++;
   endtask

   // a message of len random bytes, ended on its last byte or by a bare last beat
   task send_message(input int unsigned len, input bit bare_end);
      for (int unsigned n = 0; n < len; n++) begin
         if ($urandom_range(0, 7) == 0) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         send_beat(8'($urandom_range(0, 255)), 1'b1, (n == len - 1) && !bare_end);
      end
      if (bare_end || len == 0) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
   endtask

   task wait_digests_done();
      while (digest_sb.pending() != 0) @(posedge clock);
   endtask

   // mostly short messages, now and then one near the padding boundary
   function automatic int unsigned pick_length();
      int unsigned border_lens [6] = '{55, 56, 57, 63, 64, 120};
      case ($urandom_range(0, 9))
         0: begin
            return border_lens[$urandom_range(0, 5)];
         end
         1, 2: begin
            return $urandom_range(0, 8);
         end
         default: begin
            return $urandom_range(1, 40);
         end
      endcase
   endfunction

   // response side: random ready gaps, one long hold once the digests are flowing
   initial begin
      int unsigned gap;
      bit          held;
      held = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!held && digest_sb.words_checked >= HOLD_AFTER) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            @(posedge clock);
            while (!rsp_tvalid) @(posedge clock);
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         if ((cycle_count / 700) % 2 == 1) gap = $urandom_range(0, 4);
         else gap = 0;
         repeat (gap) begin
            rsp_tready <= 1'b0;
            @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         digest_sb.check_word(rsp_tdata, rsp_tuser, rsp_tlast);
      end
   end

   // request side and end of run
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: empty message, ignored beat, byte with last, bare end
      pace_gaps = 1'b1;
      send_beat(8'hFF, 1'b0, 1'b1);
      send_beat(8'hA5, 1'b0, 1'b0);
      send_beat(8'h61, 1'b1, 1'b0);
      send_beat(8'h62, 1'b1, 1'b0);
      send_beat(8'h63, 1'b1, 1'b1);
      send_beat(8'h00, 1'b1, 1'b0);
      send_beat(8'h00, 1'b0, 1'b1);
      send_beat(8'hFF, 1'b1, 1'b1);
      pace_gaps = 1'b0;
      send_beat(8'h00, 1'b0, 1'b1);
      send_beat(8'hFF, 1'b0, 1'b1);

      // sender quiet until every digest is out
      wait_digests_done();

      // one block with room for the length, then one that needs a second block
      pace_gaps = 1'b0;
      send_message(55, 1'($urandom_range(0, 1)));
      pace_gaps = 1'b1;
      send_message(56, 1'($urandom_range(0, 1)));
      send_message(64, 1'($urandom_range(0, 1)));

      while (items_sent < ITEM_TARGET) begin
         pace_gaps = ($urandom_range(0, 2) != 0);
         send_message(pick_length(), 1'($urandom_range(0, 1)));
      end
      req_tvalid <= 1'b0;

      wait_digests_done();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d message beats and %0d ignored beats sent, %0d messages, %0d blocks",
               items_sent, bare_steps, digest_sb.messages_hashed, digest_sb.blocks_compressed);
      $display("%0d digest words checked, %0d errors", digest_sb.words_checked, digest_sb.errors);
      if (digest_sb.errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
